// ===== design/debounced_press_classifier_top_macros.svh =====
`ifndef DEBOUNCED_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define DEBOUNCED_PRESS_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication on clk, quiet during reset
`define DPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpc same-cycle check failed");

// next-cycle implication on clk, quiet during reset
`define DPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpc next-cycle check failed");

`endif

// ===== design/dpc_pkg.sv =====
package dpc_pkg;

	localparam int TimerBits = 16;
	localparam int CfgBits   = 16;
	localparam int IdxBits   = 2;
	localparam int CmpBits   = (TimerBits > CfgBits) ? TimerBits : CfgBits;

	typedef logic [TimerBits-1:0] age_t;
	typedef logic [CfgBits-1:0]   cfg_word_t;

	typedef enum logic [IdxBits-1:0] {
		RegDebounce  = 2'd0,
		RegLongPress = 2'd1,
		RegDoubleGap = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EvNone   = 2'd0,
		EvSingle = 2'd1,
		EvDouble = 2'd2,
		EvLong   = 2'd3
	} event_t;

	localparam cfg_word_t DebounceReset  = 16'd50;
	localparam cfg_word_t LongPressReset = 16'd1000;
	localparam cfg_word_t DoubleGapReset = 16'd300;

	typedef struct packed {
		cfg_word_t debounce_ticks;
		cfg_word_t long_press_ticks;
		cfg_word_t double_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic   pending;
		event_t event_code;
		logic   new_event;
	} result_t;

	function automatic age_t age_inc(input age_t a);
		age_t r;
		r = (a == '1) ? a : age_t'(a + age_t'(1));
		return r;
	endfunction

	function automatic logic [CmpBits-1:0] age_ext(input age_t a);
		logic [CmpBits-1:0] r;
		r = CmpBits'(a);
		return r;
	endfunction

	function automatic logic [CmpBits-1:0] cfg_ext(input cfg_word_t c);
		logic [CmpBits-1:0] r;
		r = CmpBits'(c);
		return r;
	endfunction

endpackage

// ===== design/dpc_core.sv =====
module dpc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             raw,
	input  logic             ack_in,
	input  dpc_pkg::cfg_t    cfg,
	output dpc_pkg::result_t res
);

	logic            prev_raw_q;
	logic            stable_level_q;
	dpc_pkg::age_t   debounce_age_q;
	logic            press_timing_q;
	dpc_pkg::age_t   press_age_q;
	logic            awaiting_second_q;
	dpc_pkg::age_t   release_age_q;
	logic            pending_q;
	dpc_pkg::event_t last_event_q;

	logic            stable_level_d;
	dpc_pkg::age_t   debounce_age_d;
	logic            press_timing_d;
	dpc_pkg::age_t   press_age_d;
	logic            awaiting_second_d;
	dpc_pkg::age_t   release_age_d;
	logic            pending_d;
	dpc_pkg::event_t last_event_d;
	logic            fired;

	always_comb begin
		pending_d         = ack_in ? 1'b0 : pending_q;
		press_age_d       = dpc_pkg::age_inc(press_age_q);
		release_age_d     = dpc_pkg::age_inc(release_age_q);
		debounce_age_d    = (raw != prev_raw_q) ? '0 : dpc_pkg::age_inc(debounce_age_q);
		stable_level_d    = stable_level_q;
		press_timing_d    = press_timing_q;
		awaiting_second_d = awaiting_second_q;
		last_event_d      = last_event_q;
		fired             = 1'b0;

		if (dpc_pkg::age_ext(debounce_age_d) > dpc_pkg::cfg_ext(cfg.debounce_ticks)) begin
			// drop an expired double-press window
			if (awaiting_second_d &&
			    dpc_pkg::age_ext(release_age_d) > dpc_pkg::cfg_ext(cfg.double_gap_ticks)) begin
				awaiting_second_d = 1'b0;
			end
			if (raw != stable_level_q) begin
				stable_level_d = raw;
				if (raw) begin
					if (!awaiting_second_d) begin
						press_timing_d = 1'b1;
						press_age_d    = '0;
					end else begin
						last_event_d      = dpc_pkg::EvDouble;
						fired             = 1'b1;
						awaiting_second_d = 1'b0;
					end
				end else if (!awaiting_second_d && press_timing_d &&
				             dpc_pkg::age_ext(press_age_d) <
				             dpc_pkg::cfg_ext(cfg.long_press_ticks)) begin
					last_event_d      = dpc_pkg::EvSingle;
					fired             = 1'b1;
					awaiting_second_d = 1'b1;
					press_timing_d    = 1'b0;
					release_age_d     = '0;
				end
			end else if (raw && press_timing_d &&
			             dpc_pkg::age_ext(press_age_d) >=
			             dpc_pkg::cfg_ext(cfg.long_press_ticks)) begin
				last_event_d   = dpc_pkg::EvLong;
				fired          = 1'b1;
				press_timing_d = 1'b0;
			end
		end
		if (fired) begin
			pending_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q        <= 1'b0;
			stable_level_q    <= 1'b0;
			debounce_age_q    <= '0;
			press_timing_q    <= 1'b0;
			press_age_q       <= '0;
			awaiting_second_q <= 1'b0;
			release_age_q     <= '0;
			pending_q         <= 1'b0;
			last_event_q      <= dpc_pkg::EvNone;
		end else if (en) begin
			prev_raw_q        <= raw;
			stable_level_q    <= stable_level_d;
			debounce_age_q    <= debounce_age_d;
			press_timing_q    <= press_timing_d;
			press_age_q       <= press_age_d;
			awaiting_second_q <= awaiting_second_d;
			release_age_q     <= release_age_d;
			pending_q         <= pending_d;
			last_event_q      <= last_event_d;
		end
	end

	assign res.pending    = pending_d;
	assign res.event_code = last_event_d;
	assign res.new_event  = fired;

endmodule

// ===== design/debounced_press_classifier_top.sv =====
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall  | raw_level, ack
// output  | out       | out_valid / out_stall | pending, event_code, new_event
//
// One word per cycle while out_stall is low: a word is held in the input
// register, then one pass through the classifier logic loads the output register.
// The classifier state registers advance only when a word moves into the output register.
// Reset clears valid and classifier state and loads config defaults 50, 1000 and 300.
// A held output word stalls the input register, which then raises in_stall.
`include "debounced_press_classifier_top_macros.svh"

module debounced_press_classifier_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         raw_level,
	input  logic                         ack,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         pending,
	output logic [1:0]                   event_code,
	output logic                         new_event,
	input  logic                         cfg_we,
	input  logic [dpc_pkg::IdxBits-1:0]  cfg_index,
	input  logic [dpc_pkg::CfgBits-1:0]  cfg_data
);

	dpc_pkg::cfg_t    cfg_q;
	logic             v_s1;
	logic             raw_s1;
	logic             ack_s1;
	logic             v_s2;
	dpc_pkg::result_t res_s2;
	dpc_pkg::result_t res;
	logic             adv;
	logic             take;

	assign adv      = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= dpc_pkg::DebounceReset;
			cfg_q.long_press_ticks <= dpc_pkg::LongPressReset;
			cfg_q.double_gap_ticks <= dpc_pkg::DoubleGapReset;
		end else if (cfg_we) begin
			case (cfg_index)
				dpc_pkg::RegDebounce:  cfg_q.debounce_ticks   <= cfg_data;
				dpc_pkg::RegLongPress: cfg_q.long_press_ticks <= cfg_data;
				dpc_pkg::RegDoubleGap: cfg_q.double_gap_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= v_s1;
			end
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			raw_s1 <= raw_level;
			ack_s1 <= ack;
		end
		if (adv && v_s1) begin
			res_s2 <= res;
		end
	end

	dpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (v_s1 && adv),
		.raw    (raw_s1),
		.ack_in (ack_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_valid  = v_s2;
	assign pending    = res_s2.pending;
	assign event_code = res_s2.event_code;
	assign new_event  = res_s2.new_event;

	`DPC_ASSERT_IMP(a_event_sets_pending, out_valid && new_event, pending)
	`DPC_ASSERT_IMP(a_event_has_code, out_valid && new_event, event_code != dpc_pkg::EvNone)
	`DPC_ASSERT_NXT(a_stage_moves, v_s1 && adv, out_valid)
	`DPC_ASSERT_IMP(a_stall_only_when_full, in_stall, v_s1 && out_valid && out_stall)

endmodule

// ===== tb/sv/debounced_press_classifier_top_test.sv =====
module debounced_press_classifier_top_test;

	localparam int StallPct = 21;
	localparam int WatchLimit = 5000;
	localparam logic [dpc_pkg::IdxBits-1:0] RegUnused = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic raw_level;
	logic ack;
	logic out_valid;
	logic out_stall = 1'b0;
	logic pending;
	logic [1:0] event_code;
	logic new_event;
	logic cfg_we;
	logic [dpc_pkg::IdxBits-1:0] cfg_index;
	logic [dpc_pkg::CfgBits-1:0] cfg_data;

	debounced_press_classifier_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_level(raw_level),
		.ack(ack),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pending(pending),
		.event_code(event_code),
		.new_event(new_event),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// thresholds and classifier state as the block should hold them
	dpc_pkg::cfg_word_t settle_lim, hold_lim, gap_lim;
	logic last_pin, level_now, timing_on, waiting_2nd, flag_now;
	dpc_pkg::age_t settle_age, hold_age, gap_age;
	dpc_pkg::event_t recent_ev;

	dpc_pkg::result_t due_words[$];
	int faults = 0;
	bit calm;
	int quiet_cycles = 0;

	typedef struct {
		bit is_cfg;
		logic raw;
		logic ackb;
		int reps;
		bit fixed;
		dpc_pkg::result_t want;
		dpc_pkg::cfg_word_t d, l, g;
	} plan_row_t;

	plan_row_t plan[$];

	function automatic dpc_pkg::age_t bump(input dpc_pkg::age_t a);
		return (a == {dpc_pkg::TimerBits{1'b1}}) ? a : a + 1'b1;
	endfunction

	function automatic plan_row_t tick_row(input logic r, input logic a, input int n);
		plan_row_t p;
		p = '{default: '0};
		p.raw = r;
		p.ackb = a;
		p.reps = n;
		return p;
	endfunction

	function automatic plan_row_t fixed_row(input logic r, input logic a, input int n,
			input logic pf, input dpc_pkg::event_t ev, input logic nf);
		plan_row_t p;
		p = tick_row(r, a, n);
		p.fixed = 1'b1;
		p.want.pending = pf;
		p.want.event_code = ev;
		p.want.new_event = nf;
		return p;
	endfunction

	function automatic plan_row_t cfg_row(input dpc_pkg::cfg_word_t d,
			input dpc_pkg::cfg_word_t l, input dpc_pkg::cfg_word_t g);
		plan_row_t p;
		p = '{default: '0};
		p.is_cfg = 1'b1;
		p.d = d;
		p.l = l;
		p.g = g;
		return p;
	endfunction

	function automatic bit idle_roll();
		return !calm && ($urandom_range(0, 99) < StallPct);
	endfunction

	function automatic logic ack_roll();
		return ($urandom_range(0, 3) == 0);
	endfunction

	task automatic classify_tick(input logic r, input logic a, output dpc_pkg::result_t w);
		logic fired;
		fired = 1'b0;
		if (a)
			flag_now = 1'b0;
		hold_age = bump(hold_age);
		gap_age = bump(gap_age);
		settle_age = (r != last_pin) ? '0 : bump(settle_age);
		if (settle_age > settle_lim) begin
			if (waiting_2nd && gap_age > gap_lim)
				waiting_2nd = 1'b0;
			if (r != level_now) begin
				level_now = r;
				if (r) begin
					if (!waiting_2nd) begin
						timing_on = 1'b1;
						hold_age = '0;
					end else begin
						recent_ev = dpc_pkg::EvDouble;
						fired = 1'b1;
						waiting_2nd = 1'b0;
					end
				end else if (!waiting_2nd && timing_on && hold_age < hold_lim) begin
					recent_ev = dpc_pkg::EvSingle;
					fired = 1'b1;
					waiting_2nd = 1'b1;
					timing_on = 1'b0;
					gap_age = '0;
				end
			end else if (r && timing_on && hold_age >= hold_lim) begin
				recent_ev = dpc_pkg::EvLong;
				fired = 1'b1;
				timing_on = 1'b0;
			end
		end
		if (fired)
			flag_now = 1'b1;
		last_pin = r;
		w.pending = flag_now;
		w.event_code = recent_ev;
		w.new_event = fired;
	endtask

	// entered and left just after a falling edge
	task automatic send_word(input logic r, input logic a, input bit fixed,
			input dpc_pkg::result_t want);
		dpc_pkg::result_t w;
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_level <= r;
		ack <= a;
		do
			@(posedge clk);
		while (in_stall);
		classify_tick(r, a, w);
		due_words.push_back(fixed ? want : w);
		@(negedge clk);
	endtask

	task automatic set_thresholds(input dpc_pkg::cfg_word_t d, input dpc_pkg::cfg_word_t l,
			input dpc_pkg::cfg_word_t g);
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= dpc_pkg::RegDebounce;
		cfg_data <= d;
		@(negedge clk);
		cfg_index <= dpc_pkg::RegLongPress;
		cfg_data <= l;
		@(negedge clk);
		cfg_index <= dpc_pkg::RegDoubleGap;
		cfg_data <= g;
		@(negedge clk);
		cfg_index <= RegUnused;
		cfg_data <= dpc_pkg::cfg_word_t'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		settle_lim = d;
		hold_lim = l;
		gap_lim = g;
	endtask

	always @(negedge clk) begin
		out_stall <= idle_roll();
	end

	always @(posedge clk) begin
		dpc_pkg::result_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (due_words.size() == 0) begin
				faults++;
				if (faults < 40)
					$display("%0t: unexpected word pending %0b code %0d new %0b",
						$time, pending, event_code, new_event);
			end else begin
				exp_w = due_words.pop_front();
				if (exp_w.pending !== pending || exp_w.event_code !== event_code ||
						exp_w.new_event !== new_event) begin
					faults++;
					if (faults < 40)
						$display("%0t: expected pending %0b code %0d new %0b, got %0b %0d %0b",
							$time, exp_w.pending, exp_w.event_code, exp_w.new_event,
							pending, event_code, new_event);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WatchLimit) begin
				$display("debounced_press_classifier_top_test NOT OK");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int n, len, span, budget;
		logic r;
		dpc_pkg::cfg_word_t d, l, g;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_level = 1'b0;
		ack = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dpc_pkg::RegDebounce;
		cfg_data = '0;
		calm = 1'b0;
		settle_lim = dpc_pkg::DebounceReset;
		hold_lim = dpc_pkg::LongPressReset;
		gap_lim = dpc_pkg::DoubleGapReset;
		last_pin = 1'b0;
		level_now = 1'b0;
		timing_on = 1'b0;
		waiting_2nd = 1'b0;
		flag_now = 1'b0;
		settle_age = '0;
		hold_age = '0;
		gap_age = '0;
		recent_ev = dpc_pkg::EvNone;

		plan.push_back(fixed_row(1'b0, 1'b0, 4, 1'b0, dpc_pkg::EvNone, 1'b0));
		plan.push_back(fixed_row(1'b1, 1'b1, 4, 1'b0, dpc_pkg::EvNone, 1'b0));
		// debounce limit at the top accepts no level
		plan.push_back(cfg_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
		plan.push_back(fixed_row(1'b1, 1'b1, 40, 1'b0, dpc_pkg::EvNone, 1'b0));
		plan.push_back(cfg_row(16'd0, 16'd4, 16'd3));
		plan.push_back(tick_row(1'b0, 1'b0, 2));
		plan.push_back(tick_row(1'b1, 1'b0, 2));
		plan.push_back(tick_row(1'b0, 1'b0, 3));
		plan.push_back(tick_row(1'b1, 1'b0, 3));
		plan.push_back(tick_row(1'b0, 1'b0, 2));
		plan.push_back(tick_row(1'b1, 1'b0, 8));
		plan.push_back(tick_row(1'b0, 1'b1, 2));
		plan.push_back(tick_row(1'b1, 1'b0, 2));
		plan.push_back(tick_row(1'b0, 1'b0, 9));
		plan.push_back(tick_row(1'b1, 1'b1, 2));
		plan.push_back(tick_row(1'b0, 1'b0, 1));
		plan.push_back(tick_row(1'b1, 1'b0, 1));
		plan.push_back(tick_row(1'b0, 1'b1, 3));
		plan.push_back(cfg_row(16'd1, 16'd0, 16'd5));
		plan.push_back(tick_row(1'b1, 1'b0, 4));
		plan.push_back(tick_row(1'b0, 1'b0, 4));
		// long hold and long release under the widest long-press and gap limits
		plan.push_back(cfg_row(16'd1, 16'hFFFF, 16'hFFFF));
		plan.push_back(tick_row(1'b1, 1'b0, 20));
		plan.push_back(tick_row(1'b0, 1'b0, 3));
		plan.push_back(tick_row(1'b1, 1'b0, 3));
		plan.push_back(tick_row(1'b0, 1'b0, 20));
		plan.push_back(tick_row(1'b1, 1'b1, 3));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_thresholds(plan[i].d, plan[i].l, plan[i].g);
			else
				repeat (plan[i].reps)
					send_word(plan[i].raw, plan[i].ackb, plan[i].fixed, plan[i].want);
		end

		for (int p = 0; p < 7; p++) begin
			budget = 110;
			case (p)
				0: begin
					d = 16'd0;
					l = 16'd1;
					g = 16'd0;
				end
				5: begin
					d = dpc_pkg::DebounceReset;
					l = dpc_pkg::LongPressReset;
					g = dpc_pkg::DoubleGapReset;
					budget = 220;
				end
				6: begin
					d = 16'hFFFF;
					l = 16'hFFFF;
					g = 16'hFFFF;
					budget = 40;
				end
				default: begin
					d = dpc_pkg::cfg_word_t'($urandom_range(0, 6));
					l = ($urandom_range(0, 9) == 0) ? 16'd0 :
						dpc_pkg::cfg_word_t'($urandom_range(1, 40));
					g = dpc_pkg::cfg_word_t'($urandom_range(0, 30));
				end
			endcase
			set_thresholds(d, l, g);
			calm = (p == 2);
			span = int'(l) + int'(g) + 4;
			if (span > 120)
				span = 120;
			n = 0;
			while (n < budget) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						len = $urandom_range(1, 4);
						repeat (len)
							send_word(1'($urandom_range(0, 1)), ack_roll(), 1'b0, '0);
					end
					2: begin
						len = $urandom_range(1, 3);
						repeat (len) send_word(~last_pin, ack_roll(), 1'b0, '0);
					end
					default: begin
						len = ((d > 200) ? 200 : int'(d)) + 1 + $urandom_range(0, span);
						r = ~last_pin;
						repeat (len) send_word(r, ack_roll(), 1'b0, '0);
					end
				endcase
				n += len;
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (faults == 0)
			$display("debounced_press_classifier_top_test OK");
		else
			$display("debounced_press_classifier_top_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/dpc_pkg.sv
design/dpc_core.sv
design/debounced_press_classifier_top.sv
tb/sv/debounced_press_classifier_top_test.sv
